FILE: hw/rtl/golenc_pkg.sv
// shared types and constants for the golomb encoder
`default_nettype none

package golenc_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int DIV_BITS       = 16;
  localparam int RUN_BITS       = 16;
  localparam int LEN_BITS       = 5;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DIVISOR  = 2'd0,
    REG_NEG_MODE = 2'd1
  } reg_index_t;

  // divisor and the truncated binary constants derived from it
  typedef struct packed {
    logic [DIV_BITS-1:0] m;    // effective divisor, never zero
    logic [LEN_BITS-1:0] rb;   // ceil(log2 m)
    logic [DIV_BITS-1:0] cut;  // 2^rb - m
  } div_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/golenc_front.sv
// front stage: takes input values and maps them to unsigned code values
`default_nettype none

module golenc_front #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic                  neg_mode,
  output logic                  push,
  input  logic                  q_full,
  output logic [VALUE_BITS+1:0] push_data
);

  logic                  f_valid;
  logic [VALUE_BITS-1:0] f_u;
  logic                  f_su;
  logic                  f_sb;

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] u_map;
  logic                  take;

  assign neg = value[VALUE_BITS-1];
  // most negative value wraps to its exact magnitude
  assign mag = neg ? (~value + VALUE_BITS'(1)) : value;

  always_comb begin
    if (neg_mode) begin
      u_map = mag;
    end else if (neg) begin
      u_map = {mag[VALUE_BITS-2:0], 1'b0} - VALUE_BITS'(1);
    end else begin
      u_map = {value[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign push      = f_valid && !q_full;
  assign in_stall  = f_valid && q_full;
  assign take      = in_valid && !in_stall;
  assign push_data = {f_su, f_sb, f_u};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (take) begin
      f_u  <= u_map;
      f_su <= neg_mode;
      f_sb <= neg_mode && neg;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/golenc_fifo.sv
// small flop queue between front and back
`default_nettype none

module golenc_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/golenc_back.sv
// back end: pipelined restoring divider and truncated binary encode
`default_nettype none

module golenc_back #(
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  golenc_pkg::div_cfg_t          cfg,
  input  logic                          q_empty,
  input  logic [VALUE_BITS+1:0]         q_head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          sign_used,
  output logic                          sign_flag,
  output logic [golenc_pkg::RUN_BITS-1:0] zero_run,
  output logic [golenc_pkg::DIV_BITS-1:0] remainder_code,
  output logic [golenc_pkg::LEN_BITS-1:0] remainder_len
);

  localparam int VB = VALUE_BITS;
  localparam int DW = golenc_pkg::DIV_BITS;
  localparam int RW = golenc_pkg::RUN_BITS;

  // stage k holds the state after quotient bit VB-1-k has been decided
  logic          s_valid [VB];
  logic [VB-1:0] s_u     [VB];
  logic [VB-1:0] s_q     [VB];
  logic [DW-1:0] s_rem   [VB];
  logic          s_su    [VB];
  logic          s_sb    [VB];

  logic [VB-1:0] c_u     [VB];
  logic [VB-1:0] c_q     [VB];
  logic [DW-1:0] c_rem   [VB];
  logic          c_su    [VB];
  logic          c_sb    [VB];
  logic [DW:0]   c_t     [VB];
  logic          c_ge    [VB];
  logic [VB-1:0] n_q     [VB];
  logic [DW-1:0] n_rem   [VB];

  logic             adv;
  logic [VB+RW-1:0] q_ext;
  logic [DW-1:0]    r_last;
  logic             r_lt;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  always_comb begin
    for (int k = 0; k < VB; k++) begin
      if (k == 0) begin
        c_u[k]   = q_head[VB-1:0];
        c_sb[k]  = q_head[VB];
        c_su[k]  = q_head[VB+1];
        c_q[k]   = '0;
        c_rem[k] = '0;
      end else begin
        c_u[k]   = s_u[k-1];
        c_sb[k]  = s_sb[k-1];
        c_su[k]  = s_su[k-1];
        c_q[k]   = s_q[k-1];
        c_rem[k] = s_rem[k-1];
      end
      c_t[k]   = {c_rem[k], c_u[k][VB-1-k]};
      c_ge[k]  = (c_t[k] >= {1'b0, cfg.m});
      n_rem[k] = c_ge[k] ? DW'(c_t[k] - {1'b0, cfg.m}) : c_t[k][DW-1:0];
      n_q[k]   = VB'({c_q[k], c_ge[k]});
    end
  end

  // quotient saturates, remainder goes out in truncated binary
  assign q_ext  = (VB+RW)'(s_q[VB-1]);
  assign r_last = s_rem[VB-1];
  assign r_lt   = (r_last < cfg.cut);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VB; k++) begin
        s_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      s_valid[0] <= pop;
      for (int k = 1; k < VB; k++) begin
        s_valid[k] <= s_valid[k-1];
      end
      out_valid <= s_valid[VB-1];
    end
    if (adv) begin
      for (int k = 0; k < VB; k++) begin
        s_u[k]   <= c_u[k];
        s_q[k]   <= n_q[k];
        s_rem[k] <= n_rem[k];
        s_su[k]  <= c_su[k];
        s_sb[k]  <= c_sb[k];
      end
      sign_used <= s_su[VB-1];
      sign_flag <= s_sb[VB-1];
      if (q_ext > (VB+RW)'({RW{1'b1}})) begin
        zero_run <= {RW{1'b1}};
      end else begin
        zero_run <= q_ext[RW-1:0];
      end
      if (r_lt) begin
        remainder_code <= r_last;
        remainder_len  <= cfg.rb - golenc_pkg::LEN_BITS'(1);
      end else begin
        remainder_code <= r_last + cfg.cut;
        remainder_len  <= cfg.rb;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/golomb_encoder_top.sv
// top level of the golomb encoder with truncated binary remainder
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid / in_stall    | value
//  out     | output    | out_valid / out_stall  | sign_used sign_flag zero_run
//          |           |                        | remainder_code remainder_len
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index cfg_data
//
// one value per cycle sustained while out_stall is low; each value passes through
// the front register, the queue, one divider stage per quotient bit and the output register
// the divider pipeline depth, one compare and subtract per stage, sets the latency
// rst is synchronous and empties front, queue and pipeline; divisor resets to 1
// out_stall freezes the whole back pipeline; the 4-entry queue then fills and
// in_stall rises only once the front register cannot drain
`default_nettype none

module golomb_encoder_top #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input transfer
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [VALUE_BITS-1:0]          value,
  // result transfer
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  sign_used,
  output logic                                  sign_flag,
  output logic [golenc_pkg::RUN_BITS-1:0]       zero_run,
  output logic [golenc_pkg::DIV_BITS-1:0]       remainder_code,
  output logic [golenc_pkg::LEN_BITS-1:0]       remainder_len,
  // configuration write
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [golenc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [golenc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int QW = VALUE_BITS + 2;  // queue entry: sign used, sign bit, mapped value
  localparam int DW = golenc_pkg::DIV_BITS;
  localparam int LW = golenc_pkg::LEN_BITS;

  golenc_pkg::div_cfg_t cfg;
  golenc_pkg::div_cfg_t cfg_next;
  logic                 neg_mode;

  logic [DW-1:0] m_new;
  logic [DW-1:0] m_less;
  logic [LW-1:0] rb_new;

  logic          push;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  logic [QW-1:0] push_data;
  logic [QW-1:0] q_head;

  // the port takes a write every cycle
  assign cfg_ready = 1'b1;

  // derive the truncated binary constants when the divisor is written
  // a divisor of zero behaves as one
  always_comb begin
    m_new  = (cfg_data == '0) ? DW'(1) : cfg_data;
    m_less = m_new - DW'(1);
    rb_new = '0;
    for (int i = 0; i < DW; i++) begin
      if (m_less[i]) begin
        rb_new = LW'(i + 1);
      end
    end
    cfg_next.m   = m_new;
    cfg_next.rb  = rb_new;
    cfg_next.cut = DW'((17'd1 << rb_new) - {1'b0, m_new});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.m    <= DW'(1);
      cfg.rb   <= '0;
      cfg.cut  <= '0;
      neg_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (golenc_pkg::reg_index_t'(cfg_index))
        golenc_pkg::REG_DIVISOR: begin
          cfg <= cfg_next;
        end
        golenc_pkg::REG_NEG_MODE: begin
          neg_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // front: map signed value to the unsigned code value
  golenc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .neg_mode  (neg_mode),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  // queue decouples front and back
  golenc_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: divide, saturate quotient, encode remainder
  golenc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sign_used      (sign_used),
    .sign_flag      (sign_flag),
    .zero_run       (zero_run),
    .remainder_code (remainder_code),
    .remainder_len  (remainder_len)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/golenc_checker.sv
// port-level checks for the golomb encoder, bound to the top level
`default_nettype none

module golenc_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  sign_used,
  input logic                                  sign_flag,
  input logic [golenc_pkg::RUN_BITS-1:0]       zero_run,
  input logic [golenc_pkg::DIV_BITS-1:0]       remainder_code,
  input logic [golenc_pkg::LEN_BITS-1:0]       remainder_len
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(zero_run) && $stable(remainder_code)
      && $stable(remainder_len) && $stable(sign_used) && $stable(sign_flag))
    else $error("stalled result changed");

  // remainder code fits in its length
  a_code_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((remainder_code >> remainder_len) == '0) && (remainder_len <= 5'd16))
    else $error("remainder code wider than its length");

  // no sign bit without sign-magnitude
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sign_used |-> !sign_flag)
    else $error("sign bit set in interleave mode");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind golomb_encoder_top golenc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .sign_used      (sign_used),
  .sign_flag      (sign_flag),
  .zero_run       (zero_run),
  .remainder_code (remainder_code),
  .remainder_len  (remainder_len)
);

`default_nettype wire

FILE: verif/tb_golomb_encoder_top.sv
// self-checking testbench for the golomb encoder top level
`timescale 1ns / 1ps

module tb_golomb_encoder_top;

  localparam int VB = 16;
  localparam int RUN_BITS = golenc_pkg::RUN_BITS;
  localparam int DIV_BITS = golenc_pkg::DIV_BITS;
  localparam int LEN_BITS = golenc_pkg::LEN_BITS;
  localparam int CFG_DATA_BITS = golenc_pkg::CFG_DATA_BITS;
  // pipeline depth: front register, queue, divider stages and output register
  localparam int LATENCY = VB + 3;
  // idle cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int MAX_PAUSE = 18;
  localparam int N_DIRECTED = 24;

  // one codeword as described by the result channel
  typedef struct packed {
    logic                sign_used;
    logic                sign_flag;
    logic [RUN_BITS-1:0] zero_run;
    logic [DIV_BITS-1:0] remainder_code;
    logic [LEN_BITS-1:0] remainder_len;
  } code_word_t;

  // directed row: configuration, value, and optionally a hand-typed codeword
  typedef struct packed {
    logic [DIV_BITS-1:0]   divisor;
    logic                  neg_mode;
    logic signed [VB-1:0]  sample;
    logic                  typed;
    code_word_t            code;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [VB-1:0]  value = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  sign_used;
  logic                  sign_flag;
  logic [RUN_BITS-1:0]   zero_run;
  logic [DIV_BITS-1:0]   remainder_code;
  logic [LEN_BITS-1:0]   remainder_len;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  golenc_pkg::reg_index_t     cfg_index = golenc_pkg::REG_DIVISOR;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  golomb_encoder_top #(.VALUE_BITS(VB)) dut (.*);

  // testbench copy of the configuration registers, updated on each cfg transfer
  logic [DIV_BITS-1:0] divisor_shadow = 16'd1;
  logic                neg_mode_shadow = 1'b0;

  // codewords still owed by the block, oldest first
  code_word_t pending_codes[$];

  int errors = 0;
  int idle_cycles = 0;
  // when set, neither side inserts gaps or stalls
  bit steady_flow = 1'b0;
  int stall_left = 0;
  int stall_draw;

  // directed rows; typed codes cover reset config, extremes and the special cases
  directed_row_t directed_rows [N_DIRECTED] = '{
    // divisor one after reset, interleave: unary only
    '{16'd1, 1'b0, 16'sd0,      1'b1, '{1'b0, 1'b0, 16'd0,     16'd0,     5'd0}},
    '{16'd1, 1'b0, 16'sd32767,  1'b1, '{1'b0, 1'b0, 16'd65534, 16'd0,     5'd0}},
    '{16'd1, 1'b0, -16'sd32768, 1'b1, '{1'b0, 1'b0, 16'd65535, 16'd0,     5'd0}},
    '{16'd1, 1'b0, -16'sd1,     1'b1, '{1'b0, 1'b0, 16'd1,     16'd0,     5'd0}},
    '{16'd1, 1'b0, 16'sd1,      1'b1, '{1'b0, 1'b0, 16'd2,     16'd0,     5'd0}},
    // sign-magnitude, most negative value coded with its full magnitude
    '{16'd1, 1'b1, -16'sd32768, 1'b1, '{1'b1, 1'b1, 16'd32768, 16'd0,     5'd0}},
    '{16'd1, 1'b1, 16'sd32767,  1'b1, '{1'b1, 1'b0, 16'd32767, 16'd0,     5'd0}},
    '{16'd1, 1'b1, 16'sd0,      1'b1, '{1'b1, 1'b0, 16'd0,     16'd0,     5'd0}},
    '{16'd1, 1'b1, -16'sd1,     1'b1, '{1'b1, 1'b1, 16'd1,     16'd0,     5'd0}},
    // divisor zero behaves as divisor one
    '{16'd0, 1'b1, -16'sd5,     1'b1, '{1'b1, 1'b1, 16'd5,     16'd0,     5'd0}},
    '{16'd0, 1'b0, 16'sd3,      1'b1, '{1'b0, 1'b0, 16'd6,     16'd0,     5'd0}},
    // divisor three: short and long truncated binary codes
    '{16'd3, 1'b0, 16'sd0,      1'b1, '{1'b0, 1'b0, 16'd0,     16'd0,     5'd1}},
    '{16'd3, 1'b0, -16'sd1,     1'b1, '{1'b0, 1'b0, 16'd0,     16'd2,     5'd2}},
    '{16'd3, 1'b0, 16'sd1,      1'b1, '{1'b0, 1'b0, 16'd0,     16'd3,     5'd2}},
    '{16'd3, 1'b0, 16'sd7,      1'b1, '{1'b0, 1'b0, 16'd4,     16'd3,     5'd2}},
    // power of two, cutoff zero
    '{16'd2, 1'b1, -16'sd7,     1'b1, '{1'b1, 1'b1, 16'd3,     16'd1,     5'd1}},
    // largest divisors, fifteen and sixteen remainder bits
    '{16'd65535, 1'b0, 16'sd32767,  1'b1, '{1'b0, 1'b0, 16'd0, 16'd65535, 5'd16}},
    '{16'd65535, 1'b0, 16'sd0,      1'b1, '{1'b0, 1'b0, 16'd0, 16'd0,     5'd15}},
    '{16'd65535, 1'b0, -16'sd32768, 1'b1, '{1'b0, 1'b0, 16'd1, 16'd0,     5'd15}},
    '{16'd65535, 1'b1, -16'sd32768, 1'b1, '{1'b1, 1'b1, 16'd0, 16'd32769, 5'd16}},
    '{16'd32768, 1'b1, -16'sd32768, 1'b1, '{1'b1, 1'b1, 16'd1, 16'd0,     5'd15}},
    // the rest take their codeword from golomb_code
    '{16'd5,     1'b1, 16'sd12345,  1'b0, '0},
    '{16'd1000,  1'b0, -16'sd12345, 1'b0, '0},
    '{16'd65534, 1'b0, 16'sd32767,  1'b0, '0}
  };

  // golomb codeword for one sample under the shadowed configuration
  function automatic code_word_t golomb_code(logic signed [VB-1:0] sample,
                                             logic [DIV_BITS-1:0] div,
                                             logic neg_mode);
    code_word_t  cw;
    logic        negative;
    logic [31:0] magnitude;
    logic [31:0] mapped;
    logic [31:0] m;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [31:0] cut;
    int          nbits;
    cw = '0;
    negative = sample[VB-1];
    magnitude = negative ? ((32'd1 << VB) - {16'd0, sample}) : {16'd0, sample};
    if (neg_mode == 1'b0) begin
      // interleave: n -> 2n, negative n -> -2n-1
      mapped = negative ? (magnitude << 1) - 32'd1 : magnitude << 1;
    end else begin
      cw.sign_used = 1'b1;
      cw.sign_flag = negative;
      mapped = magnitude;
    end
    m = (div == '0) ? 32'd1 : {16'd0, div};
    quot = mapped / m;
    rem = mapped % m;
    if (m > 32'd1) begin
      nbits = 0;
      while ((32'd1 << nbits) < m) nbits++;
      cut = (32'd1 << nbits) - m;
      if (rem < cut) begin
        cw.remainder_code = rem[DIV_BITS-1:0];
        cw.remainder_len = LEN_BITS'(nbits - 1);
      end else begin
        cw.remainder_code = DIV_BITS'(rem + cut);
        cw.remainder_len = LEN_BITS'(nbits);
      end
    end
    cw.zero_run = (quot > 32'hFFFF) ? 16'hFFFF : quot[RUN_BITS-1:0];
    return cw;
  endfunction

  // per-item wait for either side: mostly none, sometimes up to MAX_PAUSE
  function automatic int pause_cycles();
    if (steady_flow || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  function automatic logic signed [VB-1:0] pick_sample(logic [DIV_BITS-1:0] div);
    int t;
    case ($urandom_range(0, 4))
      0, 1: t = $urandom;
      2: t = $urandom_range(0, 64) - 32;
      3: begin
        case ($urandom_range(0, 3))
          0: t = -32768;
          1: t = 32767;
          2: t = 0;
          default: t = -1;
        endcase
      end
      default: begin
        // land within a few quotients of zero so remainders straddle the cutoff
        t = $urandom_range(0, 4 * int'(div) + 3);
        if ($urandom_range(0, 1) == 1) t = -t;
      end
    endcase
    return t[VB-1:0];
  endfunction

  function automatic logic [DIV_BITS-1:0] pick_divisor(int phase);
    case (phase)
      0: return 16'd65535;
      1: return 16'd0;
      2: return 16'd1;
      default: begin
        case ($urandom_range(0, 4))
          0: return DIV_BITS'(32'd1 << $urandom_range(1, 15));
          1: return DIV_BITS'($urandom_range(2, 20));
          2: return DIV_BITS'($urandom_range(2, 300));
          3: return DIV_BITS'($urandom_range(65000, 65535));
          default: return DIV_BITS'($urandom_range(1, 65535));
        endcase
      end
    endcase
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one register transfer; cfg_valid is left high for the caller to lower
  task automatic write_reg(input golenc_pkg::reg_index_t idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      golenc_pkg::REG_DIVISOR:  divisor_shadow = data;
      golenc_pkg::REG_NEG_MODE: neg_mode_shadow = data[0];
      default: ;
    endcase
  endtask

  // drain the block, then rewrite both registers while nothing is in flight
  task automatic apply_config(input logic [DIV_BITS-1:0] div, input logic neg_mode);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    write_reg(golenc_pkg::REG_DIVISOR, div);
    write_reg(golenc_pkg::REG_NEG_MODE, {{(CFG_DATA_BITS-1){1'b0}}, neg_mode});
    cfg_valid <= 1'b0;
  endtask

  // input transfer; in_valid stays up after acceptance so back-to-back items
  // never see a low-high pair in one step
  task automatic send_value(input logic signed [VB-1:0] sample, input logic typed,
                            input code_word_t typed_code);
    int gap;
    gap = pause_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_codes.push_back(typed ? typed_code
                                  : golomb_code(sample, divisor_shadow, neg_mode_shadow));
  endtask

  // result side: after every transfer draw how long to hold out_stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = pause_cycles();
      out_stall <= (stall_draw != 0);
      stall_left <= stall_draw;
    end else if (stall_left > 0) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // compare every accepted result against the oldest pending codeword
  always @(posedge clk) begin
    code_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_codes.size() == 0) begin
        $error("result transfer with no pending codeword");
        errors++;
      end else begin
        want = pending_codes.pop_front();
        check_field("sign_used", want.sign_used, sign_used);
        check_field("sign_flag", want.sign_flag, sign_flag);
        check_field("zero_run", want.zero_run, zero_run);
        check_field("remainder_code", want.remainder_code, remainder_code);
        check_field("remainder_len", want.remainder_len, remainder_len);
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [DIV_BITS-1:0] div;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; reconfigure only where a row asks for another setting
    foreach (directed_rows[i]) begin
      if (directed_rows[i].divisor != divisor_shadow
          || directed_rows[i].neg_mode != neg_mode_shadow) begin
        apply_config(directed_rows[i].divisor, directed_rows[i].neg_mode);
      end
      send_value(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].code);
    end

    // random phases, each with its own divisor, sign mode and flow pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      div = pick_divisor(p);
      apply_config(div, p[0] ^ ($urandom_range(0, 3) == 0));
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        send_value(pick_sample(divisor_shadow), 1'b0, '0);
      end
    end

    // let everything drain, then leave room for any stray result
    in_valid <= 1'b0;
    steady_flow = 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (pending_codes.size() != 0) begin
      $error("%0d codewords never arrived", pending_codes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/golenc_pkg.sv
hw/rtl/golenc_front.sv
hw/rtl/golenc_fifo.sv
hw/rtl/golenc_back.sv
hw/rtl/golomb_encoder_top.sv
hw/rtl/golenc_checker.sv
verif/tb_golomb_encoder_top.sv
